// ===== hdl/lzbd_pkg.sv =====
// lzbd_pkg: shared types, constants and ALU op codes for the LZSS byte decoder.
// No dependencies; used by lzbd_alu, lzss_byte_decoder and lzbd_checker.
package lzbd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF    = 4096;
  localparam int unsigned MAX_LENGTH_BITS_DEF = 6;

  localparam int unsigned BUDGET_W = 24;  // output_length / bytes_left
  localparam int unsigned ALU_W    = 24;  // shared unit datapath
  localparam int unsigned DIST_W   = 17;  // (16-bit pair >> 0) + 1
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_OUTPUT_LENGTH = 1'b0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
    logic       range_error;
  } out_word_t;

  typedef enum logic [1:0] {
    ALU_ADD,     // a + b
    ALU_SHR,     // a >> b[2:0]
    ALU_SUBMOD   // (a - b) mod m, for b <= m
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] m;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             gt;   // a > b
  } alu_rsp_t;

endpackage

// ===== hdl/lzss_byte_decoder.sv =====
// lzss_byte_decoder: byte-serial LZSS decompressor with a history window.
// Uses lzbd_pkg and the shared unit lzbd_alu.
//
// Usage: compressed bytes enter on the in channel (valid/stall), one word each;
// start_of_stream marks the header byte, which loads the budget from the
// output_length register (APB, address 0). Decompressed bytes leave on the out
// channel, one word each, through an output register.
// Sequencing: every input word is accepted in the idle state and handled in the
// decode state, which ends header, control and pair-high words. A literal is
// emitted from decode and its byte sits in the output register the cycle after decode. The pair-low
// word runs 5 more setup steps on the shared unit (shift, add, compare,
// modular subtract, clip compare) and then a read state and a write state per
// copied byte, set by the registered read of the history memory. in_stall_o
// is high from acceptance until the word is fully handled.
// Stalls: while out_stall_i holds a word in the output register, a literal or
// match byte waits; header and control words still go through.
// Reset: decoder expects a header; history needs no clearing pass because the
// distance check zeroes copied bytes lying beyond those written in the current stream.
module lzss_byte_decoder #(
  parameter int unsigned WINDOW_DEPTH    = lzbd_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned MAX_LENGTH_BITS = lzbd_pkg::MAX_LENGTH_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lzbd_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lzbd_pkg::out_word_t           out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lzbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [lzbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [lzbd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LEN_W = MAX_LENGTH_BITS + 1;
  localparam int unsigned BW    = lzbd_pkg::BUDGET_W;
  localparam int unsigned AW    = lzbd_pkg::ALU_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_SHIFT, ST_DIST, ST_CHECK, ST_RDPTR, ST_CLIP,
    ST_COPY_RD, ST_COPY_WR
  } state_e;

  typedef enum logic [1:0] {
    PH_HEADER, PH_RUN, PH_PAIR, PH_DONE
  } phase_e;

  state_e              state_q;
  phase_e              phase_q;
  lzbd_pkg::in_word_t  in_q;
  logic [BW-1:0]       out_len_q;
  logic [7:0]          flag_byte_q;
  logic [3:0]          flag_pos_q;
  logic [2:0]          len_bits_q;
  logic [7:0]          pair_high_q;
  logic [BW-1:0]       bytes_left_q;
  logic [IDX_W-1:0]    wr_q;
  logic [IDX_W-1:0]    rd_q;
  logic [CNT_W-1:0]    filled_q;
  logic                header_bad_q;
  logic [lzbd_pkg::DIST_W-1:0] dist_q;
  logic                bad_q;
  logic [LEN_W-1:0]    cnt_q;
  logic                out_valid_q;
  lzbd_pkg::out_word_t out_word_q;
  logic [7:0]          mem_rd_q;
  logic [7:0]          hist_mem [WINDOW_DEPTH];

  logic                out_free;
  logic                flag_bit;
  logic [2:0]          flag_idx;
  logic                emit_lit;
  logic                emit_copy;
  logic                emit;
  lzbd_pkg::out_word_t emit_word;
  logic [7:0]          len_mask;
  logic [LEN_W-1:0]    len_first;
  logic [IDX_W-1:0]    wr_inc;
  logic [IDX_W-1:0]    rd_inc;
  logic                cfg_wr;
  lzbd_pkg::alu_req_t  alu_req;
  lzbd_pkg::alu_rsp_t  alu_rsp;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lzbd_pkg::REG_OUTPUT_LENGTH);
  assign prdata = (paddr[2] == lzbd_pkg::REG_OUTPUT_LENGTH) ?
                  lzbd_pkg::PDATA_W'(out_len_q) : '0;

  // ---------------------------------------------------------------- handshake
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- decode
  assign flag_idx = 3'(flag_pos_q - 4'd1);
  assign flag_bit = flag_byte_q[flag_idx];
  assign len_mask = 8'((9'd1 << len_bits_q) - 9'd1);
  assign len_first = LEN_W'({1'b0, in_q.in_byte & len_mask} + 9'd1);

  assign wr_inc = (wr_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wr_q + 1'b1;
  assign rd_inc = (rd_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : rd_q + 1'b1;

  assign emit_lit  = (state_q == ST_DECODE) && !in_q.start_of_stream &&
                     (phase_q == PH_RUN) && (flag_pos_q != 4'd0) && !flag_bit && out_free;
  assign emit_copy = (state_q == ST_COPY_WR) && out_free;
  assign emit      = emit_lit || emit_copy;

  always_comb begin
    emit_word.out_byte    = emit_copy ? (bad_q ? 8'd0 : mem_rd_q) : in_q.in_byte;
    emit_word.last_of_run = emit_copy ? (cnt_q == LEN_W'(1)) : 1'b1;
    emit_word.stream_done = (bytes_left_q == BW'(1));
    emit_word.range_error = header_bad_q || (emit_copy && bad_q);
  end

  // ---------------------------------------------------------------- shared unit
  always_comb begin
    alu_req.op = lzbd_pkg::ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_req.m  = AW'(WINDOW_DEPTH);
    case (state_q)
      ST_SHIFT: begin
        alu_req.op = lzbd_pkg::ALU_SHR;
        alu_req.a  = AW'({pair_high_q, in_q.in_byte});
        alu_req.b  = AW'(len_bits_q);
      end
      ST_DIST: begin
        alu_req.a = AW'(dist_q);
        alu_req.b = AW'(1);
      end
      ST_CHECK: begin
        alu_req.a = AW'(dist_q);
        alu_req.b = AW'(filled_q);
      end
      ST_RDPTR: begin
        alu_req.op = lzbd_pkg::ALU_SUBMOD;
        alu_req.a  = AW'(wr_q);
        alu_req.b  = AW'(dist_q);
      end
      ST_CLIP: begin
        alu_req.a = AW'(cnt_q);
        alu_req.b = AW'(bytes_left_q);
      end
      default: begin
      end
    endcase
  end

  lzbd_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // ---------------------------------------------------------------- history
  always_ff @(posedge clk_i) begin
    if (emit) begin
      hist_mem[wr_q] <= emit_word.out_byte;
    end
    mem_rd_q <= hist_mem[rd_q];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_HEADER;
      in_q         <= '0;
      out_len_q    <= '0;
      flag_byte_q  <= '0;
      flag_pos_q   <= '0;
      len_bits_q   <= '0;
      pair_high_q  <= '0;
      bytes_left_q <= '0;
      wr_q         <= '0;
      rd_q         <= '0;
      filled_q     <= '0;
      header_bad_q <= 1'b0;
      dist_q       <= '0;
      bad_q        <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
    end else begin
      if (cfg_wr) begin
        out_len_q <= pwdata[BW-1:0];
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_word_i;
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (in_q.start_of_stream) begin
            header_bad_q <= (in_q.in_byte > 8'(MAX_LENGTH_BITS));
            len_bits_q   <= (in_q.in_byte > 8'(MAX_LENGTH_BITS)) ?
                            3'(MAX_LENGTH_BITS) : in_q.in_byte[2:0];
            bytes_left_q <= out_len_q;
            flag_byte_q  <= '0;
            flag_pos_q   <= '0;
            pair_high_q  <= '0;
            wr_q         <= '0;
            filled_q     <= '0;
            phase_q      <= (out_len_q == '0) ? PH_DONE : PH_RUN;
            state_q      <= ST_IDLE;
          end else begin
            case (phase_q)
              PH_RUN: begin
                if (flag_pos_q == 4'd0) begin
                  flag_byte_q <= in_q.in_byte;
                  flag_pos_q  <= 4'd8;
                  state_q     <= ST_IDLE;
                end else if (!flag_bit) begin
                  if (out_free) begin
                    flag_pos_q <= flag_pos_q - 4'd1;
                    if (bytes_left_q == BW'(1)) begin
                      phase_q <= PH_DONE;
                    end
                    state_q <= ST_IDLE;
                  end
                end else begin
                  pair_high_q <= in_q.in_byte;
                  phase_q     <= PH_PAIR;
                  state_q     <= ST_IDLE;
                end
              end
              PH_PAIR: begin
                flag_pos_q <= flag_pos_q - 4'd1;
                phase_q    <= PH_RUN;
                cnt_q      <= len_first;
                state_q    <= ST_SHIFT;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SHIFT: begin
          dist_q  <= lzbd_pkg::DIST_W'(alu_rsp.res);
          state_q <= ST_DIST;
        end
        ST_DIST: begin
          dist_q  <= lzbd_pkg::DIST_W'(alu_rsp.res);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          // filled count never exceeds the window, so this covers both limits
          bad_q   <= alu_rsp.gt;
          state_q <= ST_RDPTR;
        end
        ST_RDPTR: begin
          rd_q    <= IDX_W'(alu_rsp.res);
          state_q <= ST_CLIP;
        end
        ST_CLIP: begin
          if (alu_rsp.gt) begin
            cnt_q <= LEN_W'(bytes_left_q);
          end
          state_q <= ST_COPY_RD;
        end
        ST_COPY_RD: begin
          state_q <= ST_COPY_WR;
        end
        ST_COPY_WR: begin
          if (out_free) begin
            rd_q  <= rd_inc;
            cnt_q <= cnt_q - 1'b1;
            if (cnt_q == LEN_W'(1)) begin
              if (bytes_left_q == BW'(1)) begin
                phase_q <= PH_DONE;
              end
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_COPY_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (emit) begin
        wr_q         <= wr_inc;
        bytes_left_q <= bytes_left_q - 1'b1;
        if (filled_q < CNT_W'(WINDOW_DEPTH)) begin
          filled_q <= filled_q + 1'b1;
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
        out_word_q  <= emit_word;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/lzbd_alu.sv =====
// lzbd_alu: shared add / shift / modular subtract unit with a magnitude compare.
// Combinational; the caller registers the result. Depends on lzbd_pkg.
module lzbd_alu (
  input  lzbd_pkg::alu_req_t req_i,
  output lzbd_pkg::alu_rsp_t rsp_o
);

  logic [lzbd_pkg::ALU_W-1:0] diff;

  assign diff = req_i.a - req_i.b;

  always_comb begin
    rsp_o.gt = (req_i.a > req_i.b);
    case (req_i.op)
      lzbd_pkg::ALU_ADD: begin
        rsp_o.res = req_i.a + req_i.b;
      end
      lzbd_pkg::ALU_SHR: begin
        rsp_o.res = req_i.a >> req_i.b[2:0];
      end
      lzbd_pkg::ALU_SUBMOD: begin
        rsp_o.res = (req_i.b > req_i.a) ? diff + req_i.m : diff;
      end
      default: begin
        rsp_o.res = '0;
      end
    endcase
  end

endmodule

// ===== hdl/lzbd_checker.sv =====
// lzbd_checker: port-level assertions for lzss_byte_decoder, bound to the top.
// Depends on lzbd_pkg and lzss_byte_decoder.
module lzbd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input lzbd_pkg::out_word_t          out_word_o,
  input logic                         pready
);

  // held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // the word that ends the stream ends its run too
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stream_done |-> out_word_o.last_of_run)
    else $error("stream_done without last_of_run");

  // one input word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

  // a new output word needs at least one input word behind it
  a_out_after_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output appeared while decoder idle");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && $past(pready))
    else $error("pready dropped");

endmodule

bind lzss_byte_decoder lzbd_checker u_lzbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .pready      (pready)
);
